// ===== rtl/custom_word_hash_digest_core_macros.svh =====
// Assertion macros for the word hash digest core.
`ifndef CUSTOM_WORD_HASH_DIGEST_CORE_MACROS_SVH
`define CUSTOM_WORD_HASH_DIGEST_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CWHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CWHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/cwhd_pkg.sv =====
// Types, constants and mixing functions of the word hash digest core.
package cwhd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumReg = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumReg-1:0][WordW-1:0] digest_t;

  localparam logic [1:0] MODE_FOLD128 = 2'd0;
  localparam logic [1:0] MODE_FOLD256 = 2'd1;
  localparam logic [1:0] MODE_FULL    = 2'd2;

  localparam digest_t PI_INIT = {
    32'd811174502,  32'd3594081284, 32'd582231725,  32'd3844609550,
    32'd823066470,  32'd1480865132, 32'd2117067982, 32'd2803482534,
    32'd2862089986, 32'd2307816406, 32'd2097494459, 32'd3993751058,
    32'd2884197169, 32'd4264338327, 32'd897932384,  32'd1415926535
  };

  function automatic word_t rotl32(word_t x, logic [4:0] n);
    logic [2*WordW-1:0] t;
    t = {x, x} << n;
    return t[2*WordW-1:WordW];
  endfunction

  function automatic word_t rotr32(word_t x, logic [4:0] n);
    logic [2*WordW-1:0] t;
    t = {x, x} >> n;
    return t[WordW-1:0];
  endfunction

  function automatic word_t sext8(logic [7:0] c);
    return {{(WordW-8){c[7]}}, c};
  endfunction

  function automatic word_t pack_word(logic [7:0] c0, logic [7:0] c1,
                                      logic [7:0] c2, logic [7:0] c3);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    a = sext8(c0);
    b = sext8(c1);
    c = sext8(c2);
    d = sext8(c3);
    return rotl32((a << 11) + (c << 7), 5'd24)
         + rotl32((b << 13) + (d << 11), 5'd16)
         + rotl32((d << 17) + (a << 13), 5'd8)
         + (c << 19) + (b << 17);
  endfunction

endpackage

// ===== rtl/custom_word_hash_digest_core.sv =====
// Top level of the word hash digest core: packing, register update and digest output.

// One four-character word is taken per clock cycle unless the input is stalled. A word
// passes an input register, is packed into a 32-bit value in the next register and
// then updates its digest register. A final word copies the updated digest into an
// output shift line that sends 4, 8 or 16 words, one per cycle as the output accepts
// them; the state restarts at once, so the next message flows in while the digest
// drains. A second final word reaching the update stage before the shift line is empty
// waits there, so at full rate a message needs at least one word more than the digest
// length to pass without stalling the input.
`include "custom_word_hash_digest_core_macros.svh"

module custom_word_hash_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,       // output_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // char0, char1, char2, char3
  input  logic        s_axis_tlast_i,   // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // digest_word
  output logic [3:0]  m_axis_tuser_o,   // word_index
  output logic        m_axis_tlast_o    // last_out
);
  import cwhd_pkg::*;

  logic [1:0]  mode_r_q;

  logic        a_valid_q;
  logic [31:0] a_data_q;
  logic        a_last_q;

  logic        b_valid_q;
  word_t       b_w_q;
  logic        b_last_q;

  digest_t     regs_q;
  digest_t     regs_d;
  logic [3:0]  pos_q;

  digest_t     snap_q;
  logic [4:0]  snap_cnt_q;
  logic [4:0]  snap_len;
  logic [3:0]  out_idx_q;

  logic        out_valid_q;
  word_t       out_data_q;
  logic [3:0]  out_user_q;
  logic        out_last_q;

  logic        upd_fire;
  logic        b_ready;
  logic        a_move;
  logic        snap_load;
  logic        out_load;

  word_t       w;
  word_t       mul_a;
  word_t       mul_b;
  word_t       prod;
  word_t       alt;
  logic        use_mul;
  word_t       delta;

  word_t       fa;
  word_t       fb;
  word_t       fprod;
  word_t       fold;

  // Handshake chain
  assign upd_fire        = b_valid_q && (!b_last_q || (snap_cnt_q == 5'd0));
  assign b_ready         = !b_valid_q || upd_fire;
  assign a_move          = a_valid_q && b_ready;
  assign s_axis_tready_o = !a_valid_q || a_move;
  assign cfg_ready_o     = 1'b1;
  assign snap_load       = upd_fire && b_last_q;
  assign out_load        = (snap_cnt_q != 5'd0) && (!out_valid_q || m_axis_tready_i);

  // Register update rules
  assign w = b_w_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    alt     = '0;
    use_mul = 1'b0;
    unique case (pos_q)
      4'd0: begin
        mul_a = rotl32(regs_q[0], w[4:0]); mul_b = w; use_mul = 1'b1;
      end
      4'd1: begin
        mul_a = w ^ regs_q[0]; mul_b = regs_q[0]; use_mul = 1'b1;
      end
      4'd2: alt = (regs_q[0] & w) + regs_q[1];
      4'd3: alt = ((regs_q[1] ^ regs_q[2]) | w) - regs_q[2];
      4'd4: alt = rotl32(regs_q[3] & w, regs_q[4][4:0]) + regs_q[3];
      4'd5: alt = rotr32(w, regs_q[4][4:0]) + regs_q[4];
      4'd6: begin
        mul_a = {31'd0, (w == '0)} ^ regs_q[5]; mul_b = regs_q[5]; use_mul = 1'b1;
      end
      4'd7: alt = rotr32(regs_q[6] ^ regs_q[5], w[4:0]) + regs_q[6];
      4'd8: alt = rotl32(regs_q[5] + w, regs_q[3][4:0]) - regs_q[7];
      4'd9: begin
        mul_a = w ^ {31'd0, (regs_q[7] == '0)}; mul_b = regs_q[8]; use_mul = 1'b1;
      end
      4'd10: alt = ((regs_q[7] + w) - regs_q[8]) & regs_q[9];
      4'd11: alt = rotr32(w, regs_q[3][4:0]) + regs_q[10];
      4'd12: begin
        mul_a = w + regs_q[2]; mul_b = regs_q[11]; use_mul = 1'b1;
      end
      4'd13: alt = (w & regs_q[1]) - {31'd0, (regs_q[12] == '0)};
      4'd14: alt = (regs_q[12] ^ regs_q[0]) + w;
      4'd15: begin
        mul_a = regs_q[13] - w; mul_b = regs_q[14] ^ regs_q[12]; use_mul = 1'b1;
      end
      default: alt = '0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign delta = use_mul ? prod : alt;

  always_comb begin
    regs_d        = regs_q;
    regs_d[pos_q] = regs_q[pos_q] + delta;
  end

  always_comb begin
    unique case (mode_r_q)
      MODE_FOLD128: snap_len = 5'd4;
      MODE_FOLD256: snap_len = 5'd8;
      default:      snap_len = 5'd16;
    endcase
  end

  // Digest fold from the head of the shift line
  always_comb begin
    fa = '0;
    fb = '0;
    unique case (out_idx_q[1:0])
      2'd1: begin
        fa = snap_q[0] + snap_q[8]; fb = snap_q[4] - snap_q[12];
      end
      2'd3: begin
        fa = snap_q[0] - snap_q[8]; fb = snap_q[4] + snap_q[12];
      end
      default: begin
        fa = '0; fb = '0;
      end
    endcase
  end

  assign fprod = fa * fb;

  always_comb begin
    unique case (mode_r_q)
      MODE_FOLD128: begin
        unique case (out_idx_q[1:0])
          2'd0:    fold = (snap_q[0] & snap_q[8]) + (snap_q[4] ^ snap_q[12]);
          2'd2:    fold = (snap_q[0] ^ snap_q[8]) + (snap_q[4] & snap_q[12]);
          default: fold = fprod;
        endcase
      end
      MODE_FOLD256: fold = snap_q[0] + snap_q[8];
      default:      fold = snap_q[0];
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r_q    <= MODE_FULL;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      regs_q      <= PI_INIT;
      pos_q       <= '0;
      snap_cnt_q  <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_r_q <= cfg_data_i;
      end
      if (s_axis_tready_o) begin
        a_valid_q <= s_axis_tvalid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (upd_fire) begin
        if (b_last_q) begin
          regs_q <= PI_INIT;
          pos_q  <= '0;
        end else begin
          regs_q <= regs_d;
          pos_q  <= pos_q + 4'd1;
        end
      end
      if (snap_load) begin
        snap_cnt_q <= snap_len;
        out_idx_q  <= '0;
      end else if (out_load) begin
        snap_cnt_q <= snap_cnt_q - 5'd1;
        out_idx_q  <= out_idx_q + 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      a_data_q <= s_axis_tdata_i;
      a_last_q <= s_axis_tlast_i;
    end
    if (a_move) begin
      b_w_q    <= pack_word(a_data_q[7:0], a_data_q[15:8], a_data_q[23:16], a_data_q[31:24]);
      b_last_q <= a_last_q;
    end
    if (snap_load) begin
      snap_q <= regs_d;
    end else if (out_load) begin
      snap_q[NumReg-2:0] <= snap_q[NumReg-1:1];
    end
    if (out_load) begin
      out_data_q <= fold;
      out_user_q <= out_idx_q;
      out_last_q <= (snap_cnt_q == 5'd1);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  `CWHD_ASSERT(a_snap_len, snap_load |=> (snap_cnt_q == 5'd4 || snap_cnt_q == 5'd8 || snap_cnt_q == 5'd16), "digest length not 4, 8 or 16")
  `CWHD_ASSERT(a_restart, snap_load |=> (pos_q == 4'd0 && regs_q == PI_INIT), "state not restarted after final word")
  `CWHD_ASSERT(a_stall_full, !s_axis_tready_o |-> (a_valid_q && b_valid_q), "input stalled with a free stage")
  `CWHD_ASSERT_ALWAYS(a_cnt_range, snap_cnt_q <= 5'd16, "digest count out of range")

endmodule

// ===== tb/custom_word_hash_digest_core_tb.sv =====
// Self-checking testbench for the word hash digest core: directed and random streams.
module custom_word_hash_digest_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cwhd_pkg::*;

  localparam logic [1:0]  ModeUnused  = 2'd3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned EndCycles    = 24;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned HoldOffLen   = 300;

  typedef struct packed {
    word_t       digest_word;
    logic [3:0]  word_index;
    logic        last_out;
  } digest_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  digest_t     model_regs;
  logic [3:0]  model_pos;
  logic [1:0]  model_mode;
  digest_out_t digest_expect_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned words_sent;
  int unsigned messages_sent;
  int unsigned digests_checked;
  int unsigned mode_writes;
  int unsigned errors;

  custom_word_hash_digest_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic word_t rol(word_t x, logic [4:0] n);
    return (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - n)));
  endfunction

  function automatic word_t ror(word_t x, logic [4:0] n);
    return (n == 5'd0) ? x : ((x >> n) | (x << (6'd32 - n)));
  endfunction

  function automatic word_t pack_chars(logic [7:0] c0, c1, c2, c3);
    word_t a, b, c, d;
    a = {{24{c0[7]}}, c0};
    b = {{24{c1[7]}}, c1};
    c = {{24{c2[7]}}, c2};
    d = {{24{c3[7]}}, c3};
    return rol((a << 11) + (c << 7), 5'd24)
         + rol((b << 13) + (d << 11), 5'd16)
         + rol((d << 17) + (a << 13), 5'd8)
         + (c << 19) + (b << 17);
  endfunction

  function automatic void restart_digest();
    model_regs = PI_INIT;
    model_pos  = 4'd0;
  endfunction

  function automatic void absorb_word(word_t w);
    case (model_pos)
      4'd0:  model_regs[0]  += rol(model_regs[0], w[4:0]) * w;
      4'd1:  model_regs[1]  += (w ^ model_regs[0]) * model_regs[0];
      4'd2:  model_regs[2]  += (model_regs[0] & w) + model_regs[1];
      4'd3:  model_regs[3]  += ((model_regs[1] ^ model_regs[2]) | w) - model_regs[2];
      4'd4:  model_regs[4]  += rol(model_regs[3] & w, model_regs[4][4:0]) + model_regs[3];
      4'd5:  model_regs[5]  += ror(w, model_regs[4][4:0]) + model_regs[4];
      4'd6:  model_regs[6]  += (word_t'(w == '0) ^ model_regs[5]) * model_regs[5];
      4'd7:  model_regs[7]  += ror(model_regs[6] ^ model_regs[5], w[4:0]) + model_regs[6];
      4'd8:  model_regs[8]  += rol(model_regs[5] + w, model_regs[3][4:0]) - model_regs[7];
      4'd9:  model_regs[9]  += (w ^ word_t'(model_regs[7] == '0)) * model_regs[8];
      4'd10: model_regs[10] += ((model_regs[7] + w) - model_regs[8]) & model_regs[9];
      4'd11: model_regs[11] += ror(w, model_regs[3][4:0]) + model_regs[10];
      4'd12: model_regs[12] += (w + model_regs[2]) * model_regs[11];
      4'd13: model_regs[13] += (w & model_regs[1]) - word_t'(model_regs[12] == '0);
      4'd14: model_regs[14] += (model_regs[12] ^ model_regs[0]) + w;
      default: model_regs[15] += (model_regs[13] - w) * (model_regs[14] ^ model_regs[12]);
    endcase
    model_pos = model_pos + 4'd1;
  endfunction

  function automatic void predict_digest(logic [7:0] c0, c1, c2, c3, logic is_last);
    word_t fold [16];
    int    n;
    absorb_word(pack_chars(c0, c1, c2, c3));
    if (!is_last) return;
    case (model_mode)
      MODE_FOLD128: begin
        n = 4;
        fold[0] = (model_regs[0] & model_regs[8]) + (model_regs[4] ^ model_regs[12]);
        fold[1] = (model_regs[1] + model_regs[9]) * (model_regs[5] - model_regs[13]);
        fold[2] = (model_regs[2] ^ model_regs[10]) + (model_regs[6] & model_regs[14]);
        fold[3] = (model_regs[3] - model_regs[11]) * (model_regs[7] + model_regs[15]);
      end
      MODE_FOLD256: begin
        n = 8;
        for (int i = 0; i < 8; i++) fold[i] = model_regs[i] + model_regs[i + 8];
      end
      default: begin
        n = 16;
        for (int i = 0; i < 16; i++) fold[i] = model_regs[i];
      end
    endcase
    for (int i = 0; i < n; i++) begin
      digest_expect_q.push_back(digest_out_t'{fold[i], 4'(i), i == n - 1});
    end
    restart_digest();
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] corner [4] = '{8'h00, 8'h7f, 8'h80, 8'hff};
    return ($urandom_range(7) == 0) ? corner[$urandom_range(3)] : 8'($urandom_range(255));
  endfunction

  task automatic send_word(logic [7:0] c0, c1, c2, c3, logic is_last);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c3, c2, c1, c0};
    s_axis_tlast_i  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_digest(c0, c1, c2, c3, is_last);
    words_sent++;
    if (is_last) messages_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(int unsigned len, bit noisy);
    logic is_last;
    for (int unsigned i = 0; i < len; i++) begin
      is_last = (i == len - 1) || (noisy && $urandom_range(7) == 0);
      send_word(pick_char(), pick_char(), pick_char(), pick_char(), is_last);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (digest_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] mode);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_mode = mode;
    mode_writes++;
  endtask

  // Default mode after reset, character corners, zero word on rules 0 and 6, early final.
  task automatic test_char_corners();
    logic [31:0] pattern [8] = '{
      32'h00000000, 32'hffffffff, 32'h7f7f7f7f, 32'h80808080,
      32'h00ff807f, 32'hff007f80, 32'h00000000, 32'h08040201
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 8; i++) begin
      send_word(pattern[i][7:0], pattern[i][15:8], pattern[i][23:16], pattern[i][31:24],
                i == 7);
    end
    wait_drained();
  endtask

  task automatic test_output_modes();
    logic [1:0] modes [3] = '{MODE_FOLD128, MODE_FOLD256, ModeUnused};
    for (int i = 0; i < 3; i++) begin
      write_mode(modes[i]);
      send_message(3, 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_single_zero_word();
    send_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages(int unsigned n_words, int unsigned idle_pct,
                                      int unsigned stall_pct, logic [1:0] mode);
    int unsigned start;
    int unsigned kind;
    write_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = words_sent;
    while (words_sent - start < n_words) begin
      kind = $urandom_range(9);
      if (kind <= 5) send_message(16, 1'b0);
      else if (kind <= 7) send_message(32, 1'b0);
      else if (kind == 8) send_message($urandom_range(15, 1), 1'b0);
      else send_message($urandom_range(40, 1), 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_mode(2'($urandom_range(3)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HoldOffLen;
    send_message(16, 1'b0);
    send_message(16, 1'b0);
    wait_drained();
    send_message(8, 1'b0);
    wait_drained();
  endtask

  initial begin : sink
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_left != 0) begin
        hold_off_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    digest_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_expect_q.size() == 0) begin
        $display("%0t: unexpected digest transaction: got word %h index %0d last %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = digest_expect_q.pop_front();
        digests_checked++;
        if (m_axis_tdata_o !== want.digest_word) begin
          $display("%0t: digest_word mismatch: expected %h got %h",
                   $time, want.digest_word, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== want.word_index) begin
          $display("%0t: word_index mismatch: expected %0d got %0d",
                   $time, want.word_index, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last_out) begin
          $display("%0t: last_out mismatch: expected %b got %b",
                   $time, want.last_out, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d digest words outstanding",
             $time, QuietLimit, digest_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= 2'd0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_left   = 0;
    words_sent      = 0;
    messages_sent   = 0;
    digests_checked = 0;
    mode_writes     = 0;
    errors          = 0;
    model_mode      = MODE_FULL;
    restart_digest();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_char_corners();
    test_output_modes();
    test_single_zero_word();
    test_random_messages(30, 0, 0, MODE_FULL);
    test_random_messages(30, 59, 0, MODE_FOLD128);
    test_random_messages(30, 0, 59, MODE_FOLD256);
    test_random_messages(30, 12, 12, ModeUnused);
    test_backpressure();

    wait_drained();
    repeat (EndCycles) @(posedge clk_i);
    $display("Sent %0d words in %0d messages over %0d mode writes, all four modes used;",
             words_sent, messages_sent, mode_writes);
    $display("checked %0d digest words under sender gaps, receiver stalls and a long hold-off.",
             digests_checked);
    if (errors == 0 && digest_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cwhd_pkg.sv
rtl/custom_word_hash_digest_core.sv
tb/custom_word_hash_digest_core_tb.sv
